FILE: rtl/motor_speed_pid_smoothed_pwm_defines.svh
// Assertion shorthands shared by the checkers.
// Both expect clk and arst_n in the scope where they are used.
`ifndef MOTOR_SPEED_PID_SMOOTHED_PWM_DEFINES_SVH
`define MOTOR_SPEED_PID_SMOOTHED_PWM_DEFINES_SVH

// same-cycle implication
`define MSPID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mspid_pkg.sv
package mspid_pkg;

	// structural constants
	localparam int HISTORY_DEPTH = 5;
	localparam int SPEED_BITS    = 16;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int TARGET_W  = 16;
	localparam int LIMIT_W   = 16;
	localparam int PWM_W     = 16;
	localparam int DUTY_W    = 17;
	localparam int SMOOTH_W  = 26;
	localparam int CFG_IDX_W = 3;

	// derived datapath widths
	localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
	localparam int SUM_W      = SPEED_BITS + HIST_IDX_W + 1;
	localparam int WIDE_W     = (SPEED_BITS > TARGET_W) ? SPEED_BITS : TARGET_W;
	localparam int ERR_W      = WIDE_W + HIST_IDX_W + 2;
	localparam int TERM_W     = ERR_W + 2;
	localparam int ACC_W      = TERM_W + GAIN_W + 3;
	localparam int CNT_W      = $clog2(ACC_W);
	localparam int GAIN_IDX_W = $clog2(GAIN_W);

	// divide-by-ten digit recurrence
	localparam int REM_W = 5;
	localparam logic [REM_W-1:0] DIVISOR = REM_W'(10);

	// Q.8 saturation of the smoothed duty
	localparam int SAT_W = 24;
	localparam logic [ACC_W-1:0] SAT_Q8 = ACC_W'(65535 * 256);

	localparam logic signed [ERR_W-1:0] DEPTH_E = ERR_W'(HISTORY_DEPTH);

	// register reset values
	localparam logic [GAIN_W-1:0]          GAIN_P_RST  = 16'd5248;
	localparam logic [GAIN_W-1:0]          GAIN_I_RST  = 16'd0;
	localparam logic [GAIN_W-1:0]          GAIN_D_RST  = 16'd1280;
	localparam logic signed [TARGET_W-1:0] TGT_STR_RST = 16'sd60;
	localparam logic signed [TARGET_W-1:0] TGT_TRN_RST = 16'sd59;
	localparam logic [LIMIT_W-1:0]         LIM_STR_RST = 16'd3800;
	localparam logic [LIMIT_W-1:0]         LIM_TRN_RST = 16'd3750;
	localparam logic signed [TARGET_W-1:0] TARGET_RST  = 16'sd90;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P          = 3'd0,
		CFG_GAIN_I          = 3'd1,
		CFG_GAIN_D          = 3'd2,
		CFG_TARGET_STRAIGHT = 3'd3,
		CFG_TARGET_TURN     = 3'd4,
		CFG_LIMIT_STRAIGHT  = 3'd5,
		CFG_LIMIT_TURN      = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_SUM,
		ST_ABS,
		ST_DIV,
		ST_DONE
	} state_t;

	// sample field taken as SPEED_BITS signed (zero-filled above the field)
	function automatic logic signed [SPEED_BITS-1:0] speed_ext(input logic [SAMPLE_W-1:0] v);
		logic [SAMPLE_W+SPEED_BITS-1:0] w;
		w = {{SPEED_BITS{1'b0}}, v};
		return w[SPEED_BITS-1:0];
	endfunction

endpackage

FILE: rtl/mspid_if.sv
interface mspid_sample_if import mspid_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] speed_sample;
	logic                       stop_request;
	logic                       turning;

	modport source(output valid, speed_sample, stop_request, turning, input ready);
	modport sink(input valid, speed_sample, stop_request, turning, output ready);
endinterface

interface mspid_result_if import mspid_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DUTY_W-1:0] duty_value;
	logic [PWM_W-1:0]         pwm_forward;
	logic [PWM_W-1:0]         pwm_reverse;
	logic                     pwm_update;

	modport source(output valid, duty_value, pwm_forward, pwm_reverse, pwm_update,
		input ready);
	modport sink(input valid, duty_value, pwm_forward, pwm_reverse, pwm_update,
		output ready);
endinterface

interface mspid_cfg_if import mspid_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [GAIN_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/motor_speed_pid_smoothed_pwm.sv
// Requests are handled one at a time; the 16-step gain multiply and the
//   42-step divide-by-ten recurrence share one accumulator and run back to back.
// A new request is taken while the previous result still waits on the output.
// Reset (arst_n low, async): registers to defaults, histories and duty to 0,
//   target to 90, sequencer idle, no result pending.
module motor_speed_pid_smoothed_pwm import mspid_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	mspid_sample_if.sink   sample,
	mspid_cfg_if.sink      cfg,
	mspid_result_if.source result
);

	// configuration registers
	logic [GAIN_W-1:0]          gain_p_q, gain_i_q, gain_d_q;
	logic signed [TARGET_W-1:0] target_straight_q, target_turn_q;
	logic [LIMIT_W-1:0]         limit_straight_q, limit_turn_q;

	// controller state
	logic signed [SPEED_BITS-1:0] hist_q [HISTORY_DEPTH];
	logic signed [SUM_W-1:0]      sum_q;        // running sum of hist_q
	logic signed [TARGET_W-1:0]   target_q;
	logic signed [DUTY_W-1:0]     duty_q;
	logic signed [SMOOTH_W-1:0]   smooth_q [3]; // [0] oldest

	// sequencer
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// per-request working registers
	logic signed [SPEED_BITS-1:0] s_q;
	logic                         stop_q, turn_q;
	logic signed [ERR_W-1:0]      ep_q, ei_q, ed_q;
	logic signed [ACC_W-1:0]      base_q;  // h0 + 2h1 + 3h2 + 1024*duty
	logic signed [ACC_W-1:0]      acc_q;   // product sum, then |total|, then quotient
	logic [REM_W-1:0]             rem_q;
	logic                         neg_q;

	// result register
	logic                     out_valid_q;
	logic signed [DUTY_W-1:0] out_duty_q;
	logic [PWM_W-1:0]         out_fwd_q, out_rev_q;
	logic                     out_upd_q;

	logic accept, out_free, finish;
	logic signed [SPEED_BITS-1:0] s_new;

	// multiply step
	logic [GAIN_IDX_W-1:0]    gbit;
	logic signed [TERM_W-1:0] term;

	// divide step
	logic [REM_W-1:0] trial;
	logic             q_bit;

	// final scaling, clamp and bridge split
	logic [SAT_W-1:0]           qs;
	logic signed [SMOOTH_W-1:0] smooth_mag, smooth_new;
	logic [PWM_W-1:0]           duty_mag, lim, clamp_mag;
	logic signed [DUTY_W-1:0]   duty_mag17, duty_new;
	logic [PWM_W-1:0]           fwd_new, rev_new;

	assign cfg.ready = 1'b1;
	assign s_new     = speed_ext(sample.speed_sample);
	assign accept    = sample.valid && sample.ready;
	assign out_free  = !out_valid_q || result.ready;
	assign finish    = (state_q == ST_DONE) && out_free;

	assign result.valid       = out_valid_q;
	assign result.duty_value  = out_duty_q;
	assign result.pwm_forward = out_fwd_q;
	assign result.pwm_reverse = out_rev_q;
	assign result.pwm_update  = out_upd_q;

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample.ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == '0) state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_ABS;
			ST_ABS: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// step counter: gain bit index during multiply, quotient bit during divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority case (state_q)
				ST_LOAD: cnt_q <= CNT_W'(GAIN_W - 1);
				ST_ABS:  cnt_q <= CNT_W'(ACC_W - 1);
				ST_MUL, ST_DIV: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q          <= GAIN_P_RST;
			gain_i_q          <= GAIN_I_RST;
			gain_d_q          <= GAIN_D_RST;
			target_straight_q <= TGT_STR_RST;
			target_turn_q     <= TGT_TRN_RST;
			limit_straight_q  <= LIM_STR_RST;
			limit_turn_q      <= LIM_TRN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_GAIN_P:          gain_p_q          <= cfg.data;
				CFG_GAIN_I:          gain_i_q          <= cfg.data;
				CFG_GAIN_D:          gain_d_q          <= cfg.data;
				CFG_TARGET_STRAIGHT: target_straight_q <= signed'(cfg.data);
				CFG_TARGET_TURN:     target_turn_q     <= signed'(cfg.data);
				CFG_LIMIT_STRAIGHT:  limit_straight_q  <= cfg.data;
				CFG_LIMIT_TURN:      limit_turn_q      <= cfg.data;
				default: ; // index outside the register list: dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- controller state
	// Speed history, and target unless stop is requested, move on request; smoothed history and duty on finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
			for (int i = 0; i < 3; i++) smooth_q[i] <= '0;
			sum_q    <= '0;
			target_q <= TARGET_RST;
			duty_q   <= '0;
		end else begin
			if (accept) begin
				for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_q[i] <= hist_q[i+1];
				hist_q[HISTORY_DEPTH-1] <= s_new;
				sum_q <= sum_q + SUM_W'(s_new) - SUM_W'(hist_q[0]);
				if (!sample.stop_request) begin
					target_q <= sample.turning ? target_turn_q : target_straight_q;
				end
			end
			if (finish) begin
				smooth_q[0] <= smooth_q[1];
				smooth_q[1] <= smooth_q[2];
				smooth_q[2] <= smooth_new;
				duty_q      <= duty_new;
			end
		end
	end

	// ---------------------------------------------------------------- datapath
	// MSB-first shift-add over the gain bits: all three PID terms in one pass.
	always_comb begin
		gbit = cnt_q[GAIN_IDX_W-1:0];
		term = (gain_p_q[gbit] ? TERM_W'(ep_q) : '0)
		     + (gain_i_q[gbit] ? TERM_W'(ei_q) : '0)
		     + (gain_d_q[gbit] ? TERM_W'(ed_q) : '0);
	end

	// restoring divide by ten, one quotient bit per step
	always_comb begin
		trial = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
		q_bit = (trial >= DIVISOR);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= s_new;
			stop_q <= sample.stop_request;
			turn_q <= sample.turning;
		end
		unique case (state_q)
			ST_LOAD: begin
				ep_q   <= ERR_W'(target_q) - ERR_W'(s_q);
				ei_q   <= ERR_W'(target_q) * DEPTH_E - ERR_W'(sum_q);
				ed_q   <= ERR_W'(hist_q[HISTORY_DEPTH-2]) - ERR_W'(s_q);
				base_q <= ACC_W'(smooth_q[0]) + (ACC_W'(smooth_q[1]) <<< 1);
				acc_q  <= '0;
			end
			ST_MUL: begin
				acc_q <= (acc_q <<< 1) + ACC_W'(term);
				// rest of the blend base, spread over the first multiply steps
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					base_q <= base_q + (ACC_W'(smooth_q[2]) <<< 1);
				end else if (cnt_q == CNT_W'(GAIN_W - 2)) begin
					base_q <= base_q + ACC_W'(smooth_q[2]);
				end else if (cnt_q == CNT_W'(GAIN_W - 3)) begin
					base_q <= base_q + (ACC_W'(duty_q) <<< 10);
				end
			end
			ST_SUM: acc_q <= (acc_q <<< 2) + base_q;
			ST_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				acc_q <= acc_q[ACC_W-1] ? -acc_q : acc_q;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= q_bit ? trial - DIVISOR : trial;
				acc_q <= {acc_q[ACC_W-2:0], q_bit};
			end
			default: ;
		endcase
	end

	// saturate, drop the fraction, clamp unless stopped, split into bridge legs
	always_comb begin
		qs         = ($unsigned(acc_q) > SAT_Q8) ? SAT_Q8[SAT_W-1:0] : acc_q[SAT_W-1:0];
		smooth_mag = SMOOTH_W'(qs);
		smooth_new = neg_q ? -smooth_mag : smooth_mag;
		duty_mag   = qs[SAT_W-1:8];
		lim        = turn_q ? limit_turn_q : limit_straight_q;
		clamp_mag  = (!stop_q && (duty_mag > lim)) ? lim : duty_mag;
		duty_mag17 = DUTY_W'(clamp_mag);
		duty_new   = neg_q ? -duty_mag17 : duty_mag17;
		fwd_new    = (!stop_q && !neg_q) ? clamp_mag : '0;
		rev_new    = (!stop_q && neg_q) ? clamp_mag : '0;
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_duty_q <= duty_new;
			out_fwd_q  <= fwd_new;
			out_rev_q  <= rev_new;
			out_upd_q  <= !stop_q;
		end
	end

endmodule

FILE: rtl/mspid_chk.sv
`include "motor_speed_pid_smoothed_pwm_defines.svh"

module mspid_chk import mspid_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic signed [DUTY_W-1:0] res_duty,
	input logic [PWM_W-1:0]         res_fwd,
	input logic [PWM_W-1:0]         res_rev,
	input logic                     res_upd
);

	`MSPID_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_duty) && $stable(res_fwd) && $stable(res_rev) && $stable(res_upd), "result changed while stalled")
	`MSPID_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
	`MSPID_ASSERT_NOW(a_stop_quiet, res_valid && !res_upd, res_fwd == '0 && res_rev == '0, "pwm legs driven while stopped")
	`MSPID_ASSERT_NOW(a_one_leg, res_valid, res_fwd == '0 || res_rev == '0, "both bridge legs driven")
	`MSPID_ASSERT_NOW(a_fwd_duty, res_valid && res_upd && res_fwd != '0, !res_duty[DUTY_W-1] && res_duty[PWM_W-1:0] == res_fwd, "forward leg disagrees with duty")

endmodule

bind motor_speed_pid_smoothed_pwm mspid_chk u_mspid_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_duty  (result.duty_value),
	.res_fwd   (result.pwm_forward),
	.res_rev   (result.pwm_reverse),
	.res_upd   (result.pwm_update)
);

FILE: dv/tb_motor_speed_pid_smoothed_pwm.sv
`timescale 1ns / 100ps

module tb_motor_speed_pid_smoothed_pwm;
	import mspid_pkg::*;

	// 8 ns clock
	localparam int HALF_PERIOD = 4;
	// quiet cycles allowed with no handshake on any channel; covers one request
	// plus sender gaps and short result stalls
	localparam int WATCHDOG_LIMIT = 3000;
	// settle time after the last result, longer than one request's latency
	localparam int END_TAIL = 80;
	// index 7 decodes to no register and must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	// Q.8 bound on the smoothed duty
	localparam longint SMOOTH_SAT = 64'sd65535 * 64'sd256;

	typedef struct packed {
		logic signed [DUTY_W-1:0] duty;
		logic [PWM_W-1:0]         fwd;
		logic [PWM_W-1:0]         rev;
		logic                     update;
	} duty_result_t;

	typedef struct {
		logic [GAIN_W-1:0]          gain_p;
		logic [GAIN_W-1:0]          gain_i;
		logic [GAIN_W-1:0]          gain_d;
		logic signed [TARGET_W-1:0] tgt_str;
		logic signed [TARGET_W-1:0] tgt_trn;
		logic [LIMIT_W-1:0]         lim_str;
		logic [LIMIT_W-1:0]         lim_trn;
	} loop_settings_t;

	logic clk = 1'b0;
	logic arst_n;

	mspid_sample_if sample_ch();
	mspid_cfg_if    cfg_ch();
	mspid_result_if result_ch();

	motor_speed_pid_smoothed_pwm uut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.cfg   (cfg_ch),
		.result(result_ch)
	);

	// loop state as the block should hold it
	loop_settings_t               live_set;
	logic signed [SPEED_BITS-1:0] speed_hist [HISTORY_DEPTH];
	longint                       smooth_hist [3];
	longint                       duty_reg;
	logic signed [TARGET_W-1:0]   tgt_now;

	// one predicted result per accepted sample, oldest first
	duty_result_t pending_duty_q [$];

	bit sender_gaps;
	bit sink_stalls;
	int errors;
	int items_sent;
	int stopped_items;
	int results_seen;
	int cfg_writes;
	int quiet_cycles;

	always #HALF_PERIOD clk = ~clk;

	// One control step: target reload, history shift, incremental PID in Q.8,
	// 1:2:3:4 smoothing, saturation, truncation, then clamp and bridge split
	// unless stopped.
	function automatic duty_result_t next_duty(input logic signed [SAMPLE_W-1:0] speed,
			input logic stop, input logic turn);
		duty_result_t r;
		longint       s;
		longint       sum;
		longint       raw;
		longint       smooth;
		longint       duty;
		longint       lim;
		int           i;
		s = speed;
		if (!stop)
			tgt_now = turn ? live_set.tgt_trn : live_set.tgt_str;
		for (i = 0; i < HISTORY_DEPTH - 1; i++)
			speed_hist[i] = speed_hist[i + 1];
		speed_hist[HISTORY_DEPTH - 1] = speed;
		sum = 0;
		for (i = 0; i < HISTORY_DEPTH; i++)
			sum += speed_hist[i];
		raw = duty_reg * 256
			+ (longint'(tgt_now) - s) * longint'(live_set.gain_p)
			+ (HISTORY_DEPTH * longint'(tgt_now) - sum) * longint'(live_set.gain_i)
			+ (longint'(speed_hist[HISTORY_DEPTH - 2]) - s) * longint'(live_set.gain_d);
		// signed divide truncates toward zero
		smooth = (smooth_hist[0] + 2 * smooth_hist[1] + 3 * smooth_hist[2] + 4 * raw) / 10;
		if (smooth > SMOOTH_SAT)
			smooth = SMOOTH_SAT;
		if (smooth < -SMOOTH_SAT)
			smooth = -SMOOTH_SAT;
		smooth_hist[0] = smooth_hist[1];
		smooth_hist[1] = smooth_hist[2];
		smooth_hist[2] = smooth;
		duty = smooth / 256;
		r.fwd    = '0;
		r.rev    = '0;
		r.update = !stop;
		if (!stop) begin
			lim = turn ? longint'(live_set.lim_trn) : longint'(live_set.lim_str);
			if (duty > lim)
				duty = lim;
			if (duty < -lim)
				duty = -lim;
			if (duty < 0)
				r.rev = PWM_W'(-duty);
			else
				r.fwd = PWM_W'(duty);
		end
		duty_reg = duty;
		r.duty   = duty[DUTY_W-1:0];
		return r;
	endfunction

	// Called at a falling edge; leaves valid high so back-to-back requests
	// never lower and raise it in one step.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] speed,
			input logic stop, input logic turn);
		int gap;
		if (sender_gaps && $urandom_range(99) < 9) begin
			// mostly short gaps, some long enough to land anywhere in a step
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.speed_sample <= speed;
		sample_ch.stop_request <= stop;
		sample_ch.turning      <= turn;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pending_duty_q.push_back(next_duty(speed, stop, turn));
		items_sent++;
		if (stop)
			stopped_items++;
		@(negedge clk);
	endtask

	// Drops valid and waits for every outstanding result, plus a tail.
	task automatic drain_results(input int tail);
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_duty_q.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			CFG_GAIN_P:          live_set.gain_p  = value;
			CFG_GAIN_I:          live_set.gain_i  = value;
			CFG_GAIN_D:          live_set.gain_d  = value;
			CFG_TARGET_STRAIGHT: live_set.tgt_str = value;
			CFG_TARGET_TURN:     live_set.tgt_trn = value;
			CFG_LIMIT_STRAIGHT:  live_set.lim_str = value;
			CFG_LIMIT_TURN:      live_set.lim_trn = value;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	// Only called with the block idle (after drain_results).
	task automatic configure(input loop_settings_t s, input bit poke_unused);
		write_reg(CFG_GAIN_P, s.gain_p);
		write_reg(CFG_GAIN_I, s.gain_i);
		write_reg(CFG_GAIN_D, s.gain_d);
		write_reg(CFG_TARGET_STRAIGHT, s.tgt_str);
		write_reg(CFG_TARGET_TURN, s.tgt_trn);
		write_reg(CFG_LIMIT_STRAIGHT, s.lim_str);
		write_reg(CFG_LIMIT_TURN, s.lim_trn);
		if (poke_unused)
			write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Reset settings: sample extremes, stop with the kept target of 90,
	// turn target and limit, sign changes around the straight target.
	task automatic test_reset_defaults();
		send_sample(16'sd90, 1'b1, 1'b0);
		send_sample(16'sd0, 1'b0, 1'b0);
		send_sample(16'sd60, 1'b0, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 1'b0);
		send_sample(16'sh8000, 1'b0, 1'b0);
		send_sample(16'sh8000, 1'b0, 1'b1);
		send_sample(16'sh7FFF, 1'b0, 1'b1);
		send_sample(16'sd100, 1'b1, 1'b0);
		send_sample(-16'sd5, 1'b1, 1'b1);
		send_sample(16'sd59, 1'b0, 1'b1);
		send_sample(16'sd1, 1'b0, 1'b0);
		send_sample(-16'sd1, 1'b0, 1'b0);
	endtask

	// Full-scale gains and targets, one open and one zero limit, plus a write
	// to the undecoded index. Runs of stopped samples push the unclamped duty
	// into saturation both ways.
	task automatic test_extreme_settings();
		loop_settings_t s;
		s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'hFFFF, 16'h0000};
		drain_results(8);
		configure(s, 1'b1);
		send_sample(16'sh8000, 1'b0, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 1'b1);
		repeat (4) send_sample(16'sh8000, 1'b1, 1'b0);
		repeat (3) send_sample(16'sh7FFF, 1'b1, 1'b1);
		send_sample(16'sd0, 1'b0, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 1'b0);
		send_sample(16'sh8000, 1'b0, 1'b1);
		send_sample(16'sd0, 1'b1, 1'b0);
	endtask

	// Five settings, 100 samples each. Phase 0 is the zero-gain corner with
	// swapped extreme targets; phase 2 runs with no gaps and no stalls.
	task automatic test_random_settings();
		loop_settings_t               s;
		int                           ph;
		int                           n;
		int                           stop_left;
		int                           pick;
		int                           v;
		logic                         stop;
		logic                         turn;
		logic signed [SAMPLE_W-1:0]   speed;
		logic signed [TARGET_W-1:0]   tgt;
		stop_left = 0;
		turn      = 1'b0;
		for (ph = 0; ph < 5; ph++) begin
			if (ph == 0) begin
				s = '{16'h0000, 16'h0000, 16'h0000, 16'sh8000, 16'sh7FFF, 16'h0000, 16'hFFFF};
			end else begin
				s.gain_p  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(8191));
				s.gain_i  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(256));
				s.gain_d  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
				s.tgt_str = 16'($urandom_range(400)) - 16'd200;
				s.tgt_trn = 16'($urandom_range(400)) - 16'd200;
				s.lim_str = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5000));
				s.lim_trn = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5000));
			end
			drain_results(8);
			configure(s, 1'b0);
			sender_gaps = (ph != 2);
			sink_stalls = (ph != 2);
			for (n = 0; n < 100; n++) begin
				// stops come in short runs so the held-target path gets exercised
				if (stop_left > 0) begin
					stop = 1'b1;
					stop_left--;
				end else if ($urandom_range(99) < 8) begin
					stop      = 1'b1;
					stop_left = $urandom_range(5);
				end else begin
					stop = 1'b0;
				end
				if ($urandom_range(9) == 0)
					turn = !turn;
				// mostly a loop settling around its target, some noise and extremes
				tgt  = turn ? s.tgt_trn : s.tgt_str;
				pick = $urandom_range(99);
				if (pick < 60) begin
					v     = int'(tgt) + int'($urandom_range(64)) - 32;
					speed = v[SAMPLE_W-1:0];
				end else if (pick < 85) begin
					speed = 16'($urandom);
				end else begin
					case ($urandom_range(3))
						0:       speed = 16'sh8000;
						1:       speed = 16'sh7FFF;
						2:       speed = 16'sd0;
						default: speed = -16'sd1;
					endcase
				end
				send_sample(speed, stop, turn);
			end
		end
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// Sender holds off until the pipe is empty every few requests.
	task automatic test_back_pressure();
		int                         n;
		int                         burst;
		logic                       turn;
		logic signed [TARGET_W-1:0] tgt;
		int                         v;
		burst = 0;
		for (n = 0; n < 30; n++) begin
			turn = $urandom_range(1);
			tgt  = turn ? live_set.tgt_trn : live_set.tgt_str;
			v    = int'(tgt) + int'($urandom_range(40)) - 20;
			send_sample(v[SAMPLE_W-1:0], $urandom_range(9) == 0, turn);
			if (burst == 0) begin
				drain_results(1);
				burst = $urandom_range(1, 5);
			end else begin
				burst--;
			end
		end
	endtask

	// Result ready, dropped at random about 9 percent of the time while sink_stalls is set.
	always @(negedge clk)
		result_ch.ready <= !(sink_stalls && $urandom_range(99) < 9);

	// Compare every result request against the oldest prediction.
	always @(posedge clk) begin : check_result
		duty_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_duty_q.size() == 0) begin
				$display("%0t: unexpected result: duty %0d fwd %0d rev %0d update %0b", $time,
					result_ch.duty_value, result_ch.pwm_forward, result_ch.pwm_reverse,
					result_ch.pwm_update);
				errors++;
			end else begin
				want = pending_duty_q.pop_front();
				if (result_ch.duty_value !== want.duty) begin
					$display("%0t: duty_value expected %0d actual %0d", $time, want.duty,
						result_ch.duty_value);
					errors++;
				end
				if (result_ch.pwm_forward !== want.fwd) begin
					$display("%0t: pwm_forward expected %0d actual %0d", $time, want.fwd,
						result_ch.pwm_forward);
					errors++;
				end
				if (result_ch.pwm_reverse !== want.rev) begin
					$display("%0t: pwm_reverse expected %0d actual %0d", $time, want.rev,
						result_ch.pwm_reverse);
					errors++;
				end
				if (result_ch.pwm_update !== want.update) begin
					$display("%0t: pwm_update expected %0b actual %0b", $time, want.update,
						result_ch.pwm_update);
					errors++;
				end
				results_seen++;
			end
		end
	end

	// Any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
				WATCHDOG_LIMIT, pending_duty_q.size());
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// every block input known from time zero
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.speed_sample = '0;
		sample_ch.stop_request = 1'b0;
		sample_ch.turning      = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = CFG_GAIN_P;
		cfg_ch.data            = '0;
		result_ch.ready        = 1'b0;
		sender_gaps            = 1'b1;
		sink_stalls            = 1'b1;
		errors                 = 0;
		items_sent             = 0;
		stopped_items          = 0;
		results_seen           = 0;
		cfg_writes             = 0;
		quiet_cycles           = 0;

		// predicted state after reset
		live_set = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, TGT_STR_RST, TGT_TRN_RST,
			LIM_STR_RST, LIM_TRN_RST};
		foreach (speed_hist[i])
			speed_hist[i] = '0;
		foreach (smooth_hist[i])
			smooth_hist[i] = 0;
		duty_reg = 0;
		tgt_now  = TARGET_RST;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_extreme_settings();
		test_random_settings();
		test_back_pressure();

		// nothing outstanding, then watch for stray results
		drain_results(END_TAIL);

		$display("%0d samples (%0d stopped), %0d results checked, %0d register writes",
			items_sent, stopped_items, results_seen, cfg_writes);
		$display("settings: reset, full-scale gains/targets/limits, zero gains, 4 random");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
